// File: hw/rtl/keyed_quantity_table_macros.svh
// Assertion macros shared by the keyed quantity table RTL.
// No dependencies; the bodies are empty when SYNTHESIS is defined.
`ifndef KEYED_QUANTITY_TABLE_MACROS_SVH
`define KEYED_QUANTITY_TABLE_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every clock edge outside of reset.
`define KQT_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a condition is followed by another one in the next cycle.
`define KQT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define KQT_ASSERT(lbl, clk, rst, prop, msg)
`define KQT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// File: hw/rtl/kqt_pkg.sv
// Types, codes and sizes of the keyed quantity table.
// No dependencies; imported by kqt_ctrl and the top level.
`default_nettype none

package kqt_pkg;

   localparam int ENTRIES = 16;
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W   = IDX_W + 1;
   localparam int KEY_W   = 16;
   localparam int AMT_W   = 32;
   localparam int SLOT_W  = 4;
   localparam int RAM_W   = KEY_W + AMT_W;

   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_REMOVE = 2'd1,
      OP_CHECK  = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      ST_UPDATED   = 3'd0,
      ST_INSERTED  = 3'd1,
      ST_FULL      = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_SHORT     = 3'd4,
      ST_FOUND     = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_APPLY
   } fsm_type;

   typedef struct packed {
      logic [1:0]       opcode;
      logic [KEY_W-1:0] item_key;
      logic [AMT_W-1:0] amount;
   } req_type;

   typedef struct packed {
      logic [2:0]        status;
      logic [AMT_W-1:0]  count_out;
      logic [SLOT_W-1:0] slot_out;
   } rsp_type;

   // one access to the key/count memory
   typedef struct packed {
      logic             en;
      logic             we;
      logic [IDX_W-1:0] addr;
      logic [RAM_W-1:0] wdata;
   } ram_req_type;

   // slot index as reported on the result port (low bits, zero extended)
   function automatic logic [SLOT_W-1:0] to_slot(input logic [IDX_W-1:0] idx);
      logic [31:0] wide;
      wide = 32'(idx);
      return wide[SLOT_W-1:0];
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/kqt_ram.sv
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
`default_nettype none

module kqt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             en,
   input  wire logic             we,
   input  wire logic [AW-1:0]    addr,
   input  wire logic [WIDTH-1:0] wdata,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write or read one entry per cycle
   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end else begin
            rdata_ff <= mem_ff[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// File: hw/rtl/kqt_ctrl.sv
// Sequencer of the keyed quantity table: scan, update, valid bits, result.
// Depends on kqt_pkg and keyed_quantity_table_macros.svh.
`default_nettype none
`include "keyed_quantity_table_macros.svh"

module kqt_ctrl
   import kqt_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire req_type          req_item,
   output logic                  rsp_valid,
   output rsp_type               rsp_item,
   output ram_req_type           ram_req,
   input  wire logic [RAM_W-1:0] ram_rdata
);

   fsm_type          state_ff, state_in;
   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [CNT_W-1:0] scan_idx_ff, scan_idx_in;
   logic             cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0] cmp_idx_ff, cmp_idx_in;
   logic             hit_ff, hit_in;
   logic [IDX_W-1:0] hit_idx_ff, hit_idx_in;
   logic [AMT_W-1:0] hit_count_ff, hit_count_in;
   logic             free_ff, free_in;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in;
   req_type          req_ff, req_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_item_ff, rsp_item_in;

   logic [KEY_W-1:0] rd_key;
   logic [AMT_W-1:0] rd_count;
   logic             entry_hit;
   logic             entry_free;
   logic             last_entry;
   logic [AMT_W:0]   sum_wide;
   logic [AMT_W-1:0] sum_sat;
   logic [AMT_W-1:0] diff;
   logic             short_count;

   // split the read word and compare the entry under test
   assign rd_key     = ram_rdata[RAM_W-1 -: KEY_W];
   assign rd_count   = ram_rdata[AMT_W-1:0];
   assign entry_hit  = cmp_vld_ff && valid_ff[cmp_idx_ff] && (rd_key == req_ff.item_key);
   assign entry_free = cmp_vld_ff && !valid_ff[cmp_idx_ff];
   assign last_entry = (cmp_idx_ff == IDX_W'(ENTRIES - 1));

   // arithmetic on the matched count
   assign sum_wide    = {1'b0, hit_count_ff} + {1'b0, req_ff.amount};
   assign sum_sat     = sum_wide[AMT_W] ? {AMT_W{1'b1}} : sum_wide[AMT_W-1:0];
   assign short_count = (hit_count_ff < req_ff.amount);
   assign diff        = hit_count_ff - req_ff.amount;

   // next state, memory access and result
   always_comb begin
      state_in     = state_ff;
      valid_in     = valid_ff;
      scan_idx_in  = scan_idx_ff;
      cmp_vld_in   = 1'b0;
      cmp_idx_in   = cmp_idx_ff;
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      hit_count_in = hit_count_ff;
      free_in      = free_ff;
      free_idx_in  = free_idx_ff;
      req_in       = req_ff;
      rsp_valid_in = 1'b0;
      rsp_item_in  = rsp_item_ff;
      ram_req      = '0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in      = req_item;
               scan_idx_in = '0;
               hit_in      = 1'b0;
               free_in     = 1'b0;
               state_in    = S_SCAN;
            end
         end

         S_SCAN: begin
            // remember the lowest empty slot
            if (entry_free && !free_ff) begin
               free_in     = 1'b1;
               free_idx_in = cmp_idx_ff;
            end
            if (entry_hit) begin
               hit_in       = 1'b1;
               hit_idx_in   = cmp_idx_ff;
               hit_count_in = rd_count;
               state_in     = S_APPLY;
            end else if (cmp_vld_ff && last_entry) begin
               state_in = S_APPLY;
            end else if (scan_idx_ff < CNT_W'(ENTRIES)) begin
               // issue the read of the next entry
               ram_req.en  = 1'b1;
               ram_req.addr = scan_idx_ff[IDX_W-1:0];
               cmp_vld_in  = 1'b1;
               cmp_idx_in  = scan_idx_ff[IDX_W-1:0];
               scan_idx_in = scan_idx_ff + CNT_W'(1);
            end
         end

         S_APPLY: begin
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
            rsp_item_in  = '{status: ST_NOT_FOUND, count_out: '0, slot_out: '0};
            case (req_ff.opcode)
               OP_ADD: begin
                  if (hit_ff) begin
                     ram_req     = '{en: 1'b1, we: 1'b1, addr: hit_idx_ff,
                                     wdata: {req_ff.item_key, sum_sat}};
                     rsp_item_in = '{status: ST_UPDATED, count_out: sum_sat,
                                     slot_out: to_slot(hit_idx_ff)};
                  end else if (free_ff) begin
                     ram_req     = '{en: 1'b1, we: 1'b1, addr: free_idx_ff,
                                     wdata: {req_ff.item_key, req_ff.amount}};
                     valid_in[free_idx_ff] = 1'b1;
                     rsp_item_in = '{status: ST_INSERTED, count_out: req_ff.amount,
                                     slot_out: to_slot(free_idx_ff)};
                  end else begin
                     rsp_item_in = '{status: ST_FULL, count_out: '0, slot_out: '0};
                  end
               end
               OP_REMOVE: begin
                  if (hit_ff && !short_count) begin
                     ram_req     = '{en: 1'b1, we: 1'b1, addr: hit_idx_ff,
                                     wdata: {req_ff.item_key, diff}};
                     if (diff == '0) begin
                        valid_in[hit_idx_ff] = 1'b0;
                     end
                     rsp_item_in = '{status: ST_UPDATED, count_out: diff,
                                     slot_out: to_slot(hit_idx_ff)};
                  end else if (hit_ff) begin
                     rsp_item_in = '{status: ST_SHORT, count_out: hit_count_ff,
                                     slot_out: to_slot(hit_idx_ff)};
                  end
               end
               OP_CHECK: begin
                  if (hit_ff) begin
                     rsp_item_in = '{status: ST_FOUND, count_out: hit_count_ff,
                                     slot_out: to_slot(hit_idx_ff)};
                  end
               end
               default: begin
                  rsp_item_in = '{status: ST_NOT_FOUND, count_out: '0, slot_out: '0};
               end
            endcase
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      scan_idx_ff  <= scan_idx_in;
      cmp_idx_ff   <= cmp_idx_in;
      hit_ff       <= hit_in;
      hit_idx_ff   <= hit_idx_in;
      hit_count_ff <= hit_count_in;
      free_ff      <= free_in;
      free_idx_ff  <= free_idx_in;
      req_ff       <= req_in;
      rsp_item_ff  <= rsp_item_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   `KQT_ASSERT(a_rsp_from_apply, clock, reset, rsp_valid_ff |-> $past(state_ff == S_APPLY), "result without update cycle")
   `KQT_ASSERT_NEXT(a_rsp_single, clock, reset, rsp_valid_ff, !rsp_valid_ff, "result strobe held")
   `KQT_ASSERT_NEXT(a_start_scan, clock, reset, start && !busy, state_ff == S_SCAN, "item not taken")
   `KQT_ASSERT(a_write_in_apply, clock, reset, ram_req.we |-> (state_ff == S_APPLY), "write outside update")
   `KQT_ASSERT_NEXT(a_hit_valid, clock, reset, (state_ff == S_SCAN) && entry_hit, valid_ff[hit_idx_ff], "hit on empty slot")

endmodule

`default_nettype wire

// File: hw/rtl/keyed_quantity_table.sv
// Top level of the keyed quantity table: sequencer plus key/count memory.
// Depends on kqt_pkg, kqt_ram and kqt_ctrl.
`default_nettype none

// A table of ENTRIES slots (16), each with a 16-bit key and a 32-bit count.
// Raise start with an item on req_item while busy is low; the item is taken at
// that edge and busy stays high until it is done. Add raises a matching count
// (saturating) or claims the lowest empty slot, remove subtracts when the count
// suffices and empties the slot at zero, check reports the count. Exactly one
// result comes back per item on rsp_item, marked by rsp_valid for a single
// cycle; the receiver cannot stall it and must take it in that cycle. The
// keys sit in a single-port memory that is read one entry per cycle, and a hit
// ends the scan early. A new item can be given in the cycle in which the
// previous result is shown. Slots are empty after reset; no clearing pass is
// needed.
module keyed_quantity_table
   import kqt_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_item,
   output logic         rsp_valid,
   output rsp_type      rsp_item
);

   ram_req_type      ram_req;
   logic [RAM_W-1:0] ram_rdata;

   // sequencer with valid bits and result register
   kqt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .ram_req   (ram_req),
      .ram_rdata (ram_rdata)
   );

   // key and count of every slot
   kqt_ram #(
      .WIDTH (RAM_W),
      .DEPTH (ENTRIES)
   ) u_ram (
      .clock (clock),
      .en    (ram_req.en),
      .we    (ram_req.we),
      .addr  (ram_req.addr),
      .wdata (ram_req.wdata),
      .rdata (ram_rdata)
   );

endmodule

`default_nettype wire
